// ===== rtl/assert_macros.svh =====
// Assertion macros for the deframer RTL, included by slipd_decode
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define SLIPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("slipd assertion failed");
// Condition in one cycle implies a consequence in the next cycle
`define SLIPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slipd assertion failed");
`else
`define SLIPD_ASSERT(lbl, clk, rst_n, prop)
`define SLIPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/slipd_pkg.sv =====
// Types and constants of the SLIP receive deframer
package slipd_pkg;

  // SLIP special characters
  localparam logic [7:0] CH_END     = 8'o300;
  localparam logic [7:0] CH_ESC     = 8'o333;
  localparam logic [7:0] CH_ESC_END = 8'o334;
  localparam logic [7:0] CH_ESC_ESC = 8'o335;

  // Frame size limits
  localparam int unsigned MAX_FRAME   = 2048;
  localparam int unsigned WIDTH_LIMIT = 2048;
  localparam int unsigned LIMIT_CAP_I = (MAX_FRAME < WIDTH_LIMIT) ? MAX_FRAME : WIDTH_LIMIT;
  localparam logic [11:0] LIMIT_CAP   = 12'(LIMIT_CAP_I);
  localparam logic [11:0] MAX_LEN_RST = 12'd2048;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_DATA  = 3'd1,
    EV_END   = 3'd2,
    EV_ABORT = 3'd3,
    EV_LEAVE = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_NO_ROOM = 3'd1,
    CAUSE_LINE    = 3'd2,
    CAUSE_BAD_ESC = 3'd3,
    CAUSE_TOO_LONG = 3'd4
  } cause_t;

  // One received beat as held in the input stage
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_error;
    logic       no_room;
  } rx_beat_t;

  // One decoded result
  typedef struct packed {
    event_t      ev;
    logic [7:0]  data_byte;
    logic [10:0] byte_pos;
    logic [11:0] frame_len;
    cause_t      cause;
  } result_t;

  // Clamp a written limit to the supported frame size
  function automatic logic [11:0] clamp_limit(input logic [11:0] lim);
    clamp_limit = (lim > LIMIT_CAP) ? LIMIT_CAP : lim;
  endfunction

endpackage

// ===== rtl/slipd_decode.sv =====
// Deframer state (flush, escape, cursor) and per-beat decode logic
module slipd_decode
  import slipd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  rx_beat_t    beat,
  input  logic [11:0] limit,
  output result_t     res
);

`include "assert_macros.svh"

  logic        flush_r, flush_nxt;
  logic        esc_r, esc_nxt;
  logic [11:0] cursor_r, cursor_nxt;
  logic [7:0]  dec_byte;
  logic        bad_esc;

  // Decode one beat against current state
  always_comb begin
    res        = '{ev: EV_NONE, data_byte: '0, byte_pos: '0, frame_len: '0,
                   cause: CAUSE_NONE};
    flush_nxt  = flush_r;
    esc_nxt    = esc_r;
    cursor_nxt = cursor_r;
    dec_byte   = beat.rx_byte;
    bad_esc    = 1'b0;
    if (flush_r) begin
      if (beat.rx_byte == CH_END) begin
        flush_nxt = 1'b0;
        res.ev    = EV_LEAVE;
      end
    end else if (beat.no_room || beat.line_error) begin
      flush_nxt  = 1'b1;
      cursor_nxt = '0;
      res.ev     = EV_ABORT;
      res.cause  = beat.no_room ? CAUSE_NO_ROOM : CAUSE_LINE;
    end else if (beat.rx_byte == CH_ESC) begin
      esc_nxt = 1'b1;
    end else if (beat.rx_byte == CH_END) begin
      // empty frames are dropped silently
      if (cursor_r != '0) begin
        res.ev        = EV_END;
        res.frame_len = cursor_r;
        cursor_nxt    = '0;
      end
    end else begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (beat.rx_byte == CH_ESC_END) begin
          dec_byte = CH_END;
        end else if (beat.rx_byte == CH_ESC_ESC) begin
          dec_byte = CH_ESC;
        end else begin
          bad_esc = 1'b1;
        end
      end
      if (bad_esc) begin
        flush_nxt  = 1'b1;
        cursor_nxt = '0;
        res.ev     = EV_ABORT;
        res.cause  = CAUSE_BAD_ESC;
      end else if (cursor_r >= limit) begin
        flush_nxt  = 1'b1;
        cursor_nxt = '0;
        res.ev     = EV_ABORT;
        res.cause  = CAUSE_TOO_LONG;
      end else begin
        res.ev        = EV_DATA;
        res.data_byte = dec_byte;
        res.byte_pos  = cursor_r[10:0];
        cursor_nxt    = cursor_r + 12'd1;
      end
    end
  end

  // State registers, advanced once per decoded beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_r  <= 1'b0;
      esc_r    <= 1'b0;
      cursor_r <= '0;
    end else if (step) begin
      flush_r  <= flush_nxt;
      esc_r    <= esc_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  // An abort always leaves the deframer flushing with an empty frame
  `SLIPD_ASSERT_NEXT(a_abort_flush, clk, rst_n, step && res.ev == EV_ABORT,
                     flush_r && cursor_r == '0)
  // Cursor never runs past the largest supported frame
  `SLIPD_ASSERT(a_cursor_cap, clk, rst_n, cursor_r <= LIMIT_CAP)
  // A data byte moves the cursor exactly one position forward
  `SLIPD_ASSERT_NEXT(a_data_adv, clk, rst_n, step && res.ev == EV_DATA,
                     cursor_r == 12'($past(cursor_r)) + 12'd1)

endmodule

// ===== rtl/slip_receive_deframer.sv =====
// Top level: input stage, decode, result stage and limit register
// A beat held in the input stage is decoded and its result registered in the result stage on out_*.
// Throughput: one beat per cycle; in_ready is low only while both stages hold
// a beat and out_ready is low.
// Reset (rst_n low, synchronous): both stages empty, not flushing, no escape
// pending, cursor 0, frame limit 2048. Configuration is always ready.
module slip_receive_deframer
  import slipd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_line_error,
  input  logic        in_no_room,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [10:0] out_byte_pos,
  output logic [11:0] out_frame_len,
  output logic [2:0]  out_abort_cause,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_max_frame_len
);

  logic        in_vld_r;
  rx_beat_t    beat_r;
  logic        out_vld_r;
  result_t     res_r;
  result_t     res;
  logic [11:0] limit_r;
  logic        advance;
  logic        step;

  assign advance   = !out_vld_r || out_ready;
  assign step      = in_vld_r && advance;
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  // Effective frame limit, clamped when written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= clamp_limit(MAX_LEN_RST);
    end else if (cfg_valid) begin
      limit_r <= clamp_limit(cfg_max_frame_len);
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= '{rx_byte: in_rx_byte, line_error: in_line_error, no_room: in_no_room};
    end
  end

  slipd_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .beat  (beat_r),
    .limit (limit_r),
    .res   (res)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_event_res   = res_r.ev;
  assign out_data_byte   = res_r.data_byte;
  assign out_byte_pos    = res_r.byte_pos;
  assign out_frame_len   = res_r.frame_len;
  assign out_abort_cause = res_r.cause;

endmodule
